// File: src/fkra_pkg.sv
package fkra_pkg;

  localparam int VALUE_W   = 7;
  localparam int KEY_W     = VALUE_W + 1;
  localparam int RANK_W    = 7;
  localparam int GRP       = 8;
  localparam int GRP_SUM_W = 4;

  typedef struct packed {
    logic [VALUE_W-1:0] item_value;
    logic               liked;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_rank;
    logic              dropped;
  } out_item_t;

  typedef struct packed {
    logic store;
    logic drop;
    logic add_sum;
    logic grp_en;
    logic shift;
    logic clear;
  } fkra_cmd_t;

  typedef struct packed {
    logic full;
    logic emit_last;
  } fkra_status_t;

endpackage

// File: src/fkra_ctrl.sv
module fkra_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fkra_pkg::fkra_status_t status,
  output fkra_pkg::fkra_cmd_t    cmd
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_CNT  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    last_nxt  = last_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        in_ready    = 1'b1;
        // rank of the previous item gets its count of lower keys now
        cmd.add_sum = pend_r;
        pend_nxt    = 1'b0;
        if (in_valid) begin
          if (status.full) begin
            cmd.drop = 1'b1;
            if (in_last) state_nxt = S_EMIT;
          end else begin
            cmd.store = 1'b1;
            last_nxt  = in_last;
            state_nxt = S_CNT;
          end
        end
      end
      S_CNT: begin
        cmd.grp_en = 1'b1;
        if (last_r) begin
          state_nxt = S_FIN;
        end else begin
          pend_nxt  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_FIN: begin
        cmd.add_sum = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift = 1'b1;
          if (status.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pend_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// File: src/fkra_dp.sv
module fkra_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fkra_pkg::fkra_cmd_t    cmd,
  output fkra_pkg::fkra_status_t status,
  input  fkra_pkg::in_item_t     in_data,
  output fkra_pkg::out_item_t    out_data
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int NG    = (MAX_ITEMS + fkra_pkg::GRP - 1) / fkra_pkg::GRP;
  localparam int PAD   = NG * fkra_pkg::GRP;

  logic [fkra_pkg::KEY_W-1:0]  key_r  [MAX_ITEMS];
  logic [fkra_pkg::RANK_W-1:0] rank_r [MAX_ITEMS];
  logic [fkra_pkg::RANK_W-1:0] rank_nxt [MAX_ITEMS];
  logic [PAD-1:0]              cmp_r, cmp_nxt;
  logic [fkra_pkg::GRP_SUM_W-1:0] grp_r [NG];
  logic [fkra_pkg::RANK_W-1:0] sum_total;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            cnt_m1;
  logic [IDX_W-1:0]            wr_idx, pend_idx;
  logic [IDX_W-1:0]            emit_r, emit_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [fkra_pkg::KEY_W-1:0]  new_key;
  logic [MAX_ITEMS-1:0]        inc;

  assign new_key  = {in_data.liked, in_data.item_value};
  assign cnt_m1   = count_r - CNT_W'(1);
  assign wr_idx   = count_r[IDX_W-1:0];
  assign pend_idx = cnt_m1[IDX_W-1:0];

  assign status.full      = (count_r == CNT_W'(MAX_ITEMS));
  assign status.emit_last = (emit_r == cnt_m1[IDX_W-1:0]);

  // compare the new key against every stored item at once
  always_comb begin
    cmp_nxt = '0;
    inc     = '0;
    for (int j = 0; j < MAX_ITEMS; j++) begin
      if (CNT_W'(j) < count_r) begin
        cmp_nxt[j] = (key_r[j] <= new_key);
        inc[j]     = cmd.store && (key_r[j] > new_key);
      end
    end
  end

  always_comb begin
    sum_total = '0;
    for (int g = 0; g < NG; g++) begin
      sum_total = sum_total + fkra_pkg::RANK_W'(grp_r[g]);
    end
  end

  for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
    always_comb begin
      rank_nxt[j] = rank_r[j];
      if (cmd.shift) begin
        if (j < MAX_ITEMS - 1) rank_nxt[j] = rank_r[(j + 1) % MAX_ITEMS];
        else rank_nxt[j] = '0;
      end else if (cmd.store && (wr_idx == IDX_W'(j))) begin
        rank_nxt[j] = fkra_pkg::RANK_W'(1);
      end else begin
        rank_nxt[j] = rank_r[j] + fkra_pkg::RANK_W'(inc[j]) +
                      ((cmd.add_sum && (pend_idx == IDX_W'(j))) ? sum_total : '0);
      end
    end

    always_ff @(posedge clk) begin
      rank_r[j] <= rank_nxt[j];
      if (cmd.store && (wr_idx == IDX_W'(j))) key_r[j] <= new_key;
    end
  end

  // first half of the lower-key count: bits summed in groups of eight
  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_ff @(posedge clk) begin
      if (cmd.grp_en) grp_r[g] <= fkra_pkg::GRP_SUM_W'($countones(cmp_r[g*fkra_pkg::GRP +:
                                                                     fkra_pkg::GRP]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) cmp_r <= cmp_nxt;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    emit_nxt  = emit_r;
    if (cmd.store) count_nxt = count_r + CNT_W'(1);
    if (cmd.drop) ovf_nxt = 1'b1;
    if (cmd.shift) emit_nxt = emit_r + IDX_W'(1);
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      emit_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      emit_r  <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign out_data.rank      = rank_r[0];
  assign out_data.last_rank = status.emit_last;
  assign out_data.dropped   = ovf_r;

endmodule

// File: src/flagged_key_rank_assign.sv
// loading: a stored item is transferred, then group-counted in its own state; an item
// beyond capacity is dropped on transfer; ranks are kept up to date in a row of cells
// after the last item the ranks settle (group count, then final sum; skipped if the closing
// item is dropped), then one result per cycle while out_ready is high, n results in load
// order, shifted out of the cell row
// reset: synchronous active-low rst_n empties the set and clears the overflow flag
module flagged_key_rank_assign #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fkra_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fkra_pkg::out_item_t out_data
);

  fkra_pkg::fkra_cmd_t    cmd;
  fkra_pkg::fkra_status_t status;

  fkra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_data.last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fkra_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// File: tb/sv/fkra_rank_check.sv
module fkra_rank_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fkra_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fkra_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  ranks_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;

  logic [fkra_pkg::VALUE_W-1:0] set_values [CAPACITY];
  logic                         set_liked  [CAPACITY];
  int                           set_size;
  logic                         set_overflow;
  fkra_pkg::out_item_t          rank_queue [$];

  // rank of each stored item: one plus the count of items with a smaller key, or an equal
  // key and an earlier load position
  task automatic rank_set();
    logic [fkra_pkg::KEY_W-1:0] key_i;
    logic [fkra_pkg::KEY_W-1:0] key_j;
    int                         below;
    fkra_pkg::out_item_t        r;
    for (int i = 0; i < set_size; i++) begin
      key_i = {set_liked[i], set_values[i]};
      below = 0;
      for (int j = 0; j < set_size; j++) begin
        key_j = {set_liked[j], set_values[j]};
        if (key_j < key_i || (key_j == key_i && j < i)) below++;
      end
      r.rank      = fkra_pkg::RANK_W'(below + 1);
      r.last_rank = (i == set_size - 1);
      r.dropped   = set_overflow;
      rank_queue.insert(rank_queue.size(), r);
    end
  endtask

  always @(posedge clk) begin
    fkra_pkg::out_item_t exp_rank;
    if (!rst_n) begin
      set_size     = 0;
      set_overflow = 1'b0;
      rank_queue.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (set_size < CAPACITY) begin
          set_values[set_size] = in_data.item_value;
          set_liked[set_size]  = in_data.liked;
          set_size++;
        end else begin
          set_overflow = 1'b1;
        end
        if (in_data.last) begin
          rank_set();
          set_size     = 0;
          set_overflow = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (rank_queue.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected rank %0d last_rank %b dropped %b", $realtime,
                     out_data.rank, out_data.last_rank, out_data.dropped);
          mismatches++;
        end else begin
          exp_rank = rank_queue.pop_front();
          if (out_data.rank !== exp_rank.rank || out_data.last_rank !== exp_rank.last_rank ||
              out_data.dropped !== exp_rank.dropped) begin
            if (mismatches < 10)
              $display("%0t: rank mismatch: expected %0d/%b/%b, got %0d/%b/%b", $realtime,
                       exp_rank.rank, exp_rank.last_rank, exp_rank.dropped,
                       out_data.rank, out_data.last_rank, out_data.dropped);
            mismatches++;
          end
        end
      end
    end
    ranks_owed = rank_queue.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  fkra_pkg::in_item_t  in_data   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  fkra_pkg::out_item_t out_data;
  int                  mismatches;
  int                  ranks_owed;

  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  flagged_key_rank_assign u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fkra_rank_check u_rank_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .ranks_owed (ranks_owed)
  );

  // receiver: modes of free flow, random stalls, sparse ready and long stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_left % 24) >= 20);
    endcase
  end

  task automatic send_item(input logic [fkra_pkg::VALUE_W-1:0] value, input logic liked,
                           input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid        <= 1'b1;
    in_data.item_value <= value;
    in_data.liked   <= liked;
    in_data.last    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // mix of full-range values, nominal values and a narrow band that forces ties
  function automatic logic [fkra_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 2))
      0:       return fkra_pkg::VALUE_W'($urandom_range(0, 127));
      1:       return fkra_pkg::VALUE_W'($urandom_range(1, 64));
      default: return fkra_pkg::VALUE_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_set(input int size);
    for (int k = 0; k < size; k++)
      send_item(pick_value(), 1'($urandom_range(0, 1)), k == size - 1);
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (ranks_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int pick;
    int size;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single-item sets at both value extremes
    send_item(7'd0, 1'b0, 1'b1);
    send_item(7'd127, 1'b1, 1'b1);
    // both groups with ties in value
    send_item(7'd5, 1'b0, 1'b0);
    send_item(7'd5, 1'b1, 1'b0);
    send_item(7'd5, 1'b0, 1'b0);
    send_item(7'd127, 1'b0, 1'b0);
    send_item(7'd0, 1'b1, 1'b0);
    send_item(7'd64, 1'b1, 1'b1);
    // all liked, descending
    send_item(7'd64, 1'b1, 1'b0);
    send_item(7'd33, 1'b1, 1'b0);
    send_item(7'd2, 1'b1, 1'b0);
    send_item(7'd1, 1'b1, 1'b1);
    // equal keys throughout, order by load position
    send_item(7'd10, 1'b0, 1'b0);
    send_item(7'd10, 1'b0, 1'b0);
    send_item(7'd10, 1'b0, 1'b0);
    send_item(7'd10, 1'b0, 1'b1);
    send_item(7'd1, 1'b0, 1'b0);
    send_item(7'd64, 1'b1, 1'b0);
    send_item(7'd127, 1'b0, 1'b1);
    wait_drained();

    // overflow: two items past capacity, the closing one among them
    send_set(66);
    while (items_sent < 370) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) size = $urandom_range(13, 64);
      else if (pick == 1) size = $urandom_range(64, 68);
      else size = $urandom_range(1, 12);
      send_set(size);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (ranks_owed != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && ranks_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
